@@ design/dual_motor_speed_ramp_defines.svh @@
// ----------------------------------------------------------------------------
// dual_motor_speed_ramp_defines
// Assertion macros shared by the checker of the dual motor speed ramp.
// ----------------------------------------------------------------------------
`ifndef DUAL_MOTOR_SPEED_RAMP_DEFINES_SVH
`define DUAL_MOTOR_SPEED_RAMP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DMSR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("dual_motor_speed_ramp: check failed");

// Consequent must hold in the cycle after the antecedent.
`define DMSR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("dual_motor_speed_ramp: check failed");

`endif

@@ design/dmsr_pkg.sv @@
// ----------------------------------------------------------------------------
// dmsr_pkg
// Types and constants of the dual motor speed ramp.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dmsr_pkg;

	localparam int CMD_W   = 11;
	localparam int MAG_W   = 11;
	localparam int DUTY_W  = 7;
	localparam int STEP_W  = 7;
	localparam int SCALE_W = 8;
	localparam int PROD_W  = MAG_W + SCALE_W;
	localparam int IDX_W   = 2;
	localparam int DATA_W  = 8;

	localparam logic [DUTY_W-1:0] DUTY_MAX = 7'd100;
	localparam logic [DUTY_W-1:0] DUTY_ONE = 7'd40;
	localparam logic [DUTY_W-1:0] DUTY_TWO = 7'd60;
	localparam logic [MAG_W-1:0]  SCALE_BIAS = 11'd78;
	// products at or above (DUTY_MAX + 1) * 40 saturate
	localparam logic [PROD_W-1:0] SAT_PROD = 19'd4040;
	// floor(x / 5) == (x * 205) >> 10 for x below 1024
	localparam logic [16:0]       RECIP_FIVE = 17'd205;

	localparam logic [STEP_W-1:0]  ACCEL_RESET = 7'd5;
	localparam logic [STEP_W-1:0]  DECEL_RESET = 7'd5;
	localparam logic [SCALE_W-1:0] SCALE_RESET = 8'd30;

	localparam logic [IDX_W-1:0] REG_ACCEL = 2'd0;
	localparam logic [IDX_W-1:0] REG_DECEL = 2'd1;
	localparam logic [IDX_W-1:0] REG_SCALE = 2'd2;

	typedef struct packed {
		logic              neg;
		logic [MAG_W-1:0]  mag;
		logic [PROD_W-1:0] prod;
	} dmsr_cmd_t;

	typedef struct packed {
		logic              rev;
		logic [DUTY_W-1:0] mag;
	} dmsr_target_t;

	typedef struct packed {
		logic [STEP_W-1:0] accel;
		logic [STEP_W-1:0] decel;
	} dmsr_steps_t;

endpackage

`default_nettype wire

@@ design/dmsr_shape.sv @@
// ----------------------------------------------------------------------------
// dmsr_shape
// Turns a registered command magnitude and scaled product into a target duty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dmsr_shape
	import dmsr_pkg::*;
(
	input  dmsr_cmd_t    cmd,
	output dmsr_target_t target
);

	logic [16:0]       quot;
	logic [DUTY_W-1:0] mag;

	// divide by 40 as a shift by three and a reciprocal multiply by five
	assign quot = {8'd0, cmd.prod[11:3]} * RECIP_FIVE;

	always_comb begin
		if (cmd.mag == MAG_W'(0)) begin
			mag = '0;
		end else if (cmd.mag == MAG_W'(1)) begin
			mag = DUTY_ONE;
		end else if (cmd.mag == MAG_W'(2)) begin
			mag = DUTY_TWO;
		end else if (cmd.prod >= SAT_PROD) begin
			mag = DUTY_MAX;
		end else begin
			mag = quot[16:10];
		end
	end

	assign target.mag = mag;
	assign target.rev = cmd.neg && (mag != '0);

endmodule

`default_nettype wire

@@ design/dmsr_ramp.sv @@
// ----------------------------------------------------------------------------
// dmsr_ramp
// Direction and duty of one motor, stepped toward a target once per word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dmsr_ramp
	import dmsr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  dmsr_target_t      target,
	input  dmsr_steps_t       steps,
	output logic              reverse,
	output logic [DUTY_W-1:0] duty
);

	logic              dir_q;
	logic [DUTY_W-1:0] duty_q;
	logic              dir_d;
	logic [DUTY_W-1:0] duty_d;
	logic [DUTY_W-1:0] rise_gap;
	logic [DUTY_W-1:0] fall_gap;

	assign rise_gap = target.mag - duty_q;
	assign fall_gap = duty_q - target.mag;

	always_comb begin
		dir_d  = dir_q;
		duty_d = duty_q;
		if (duty_q == target.mag && (target.mag == '0 || dir_q == target.rev)) begin
			// already there: zero duty matches either direction
		end else if (dir_q != target.rev) begin
			// slow down first, flip only once stopped
			if (duty_q == '0) begin
				dir_d = target.rev;
			end else begin
				duty_d = duty_q - ((steps.decel < duty_q) ? steps.decel : duty_q);
			end
		end else if (target.mag > duty_q) begin
			duty_d = duty_q + ((steps.accel < rise_gap) ? steps.accel : rise_gap);
		end else begin
			duty_d = duty_q - ((steps.decel < fall_gap) ? steps.decel : fall_gap);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q  <= 1'b0;
			duty_q <= '0;
		end else if (en) begin
			dir_q  <= dir_d;
			duty_q <= duty_d;
		end
	end

	assign reverse = dir_q;
	assign duty    = duty_q;

endmodule

`default_nettype wire

@@ design/dual_motor_speed_ramp.sv @@
// One word (a left and a right velocity command) is accepted per cycle while
// in_ready is high. The scaled product is registered at acceptance, the
// target duty is registered when that word advances, and the ramp update
// of each motor's direction and duty lands in the output register after
// that. The output register is the kept motor state itself. A stall on the
// output holds the two internal stages and backs up to in_ready; with the
// output free, one word leaves per cycle. Register writes (acceleration
// step, deceleration step, scale) take effect at once; the user must make
// them only while no word is in flight, which the block does not enforce.
// ----------------------------------------------------------------------------
// dual_motor_speed_ramp
// Slew-rate limited PWM duty and direction for two motors.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dual_motor_speed_ramp
	import dmsr_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [CMD_W-1:0]  left_command,
	input  logic signed [CMD_W-1:0]  right_command,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic                     left_reverse,
	output logic [DUTY_W-1:0]        left_duty,
	output logic                     right_reverse,
	output logic [DUTY_W-1:0]        right_duty,
	input  logic                     wr_en,
	input  logic [IDX_W-1:0]         wr_index,
	input  logic [DATA_W-1:0]        wr_data
);

	function automatic dmsr_cmd_t prep_cmd(input logic [CMD_W-1:0] cmd,
			input logic [SCALE_W-1:0] scale);
		dmsr_cmd_t        r;
		logic [MAG_W-1:0] biased;
		r.neg  = cmd[CMD_W-1];
		r.mag  = r.neg ? MAG_W'(~cmd + 1'b1) : MAG_W'(cmd);
		biased = r.mag + SCALE_BIAS;
		r.prod = PROD_W'(biased) * PROD_W'(scale);
		return r;
	endfunction

	logic [STEP_W-1:0]  accel_q;
	logic [STEP_W-1:0]  decel_q;
	logic [SCALE_W-1:0] scale_q;
	dmsr_steps_t        steps;

	logic         valid_s1, valid_s2, out_valid_q;
	dmsr_cmd_t    left_s1, right_s1;
	dmsr_target_t left_s2, right_s2;
	dmsr_target_t left_tgt, right_tgt;
	logic         in_acc, adv_s1, adv_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accel_q <= ACCEL_RESET;
			decel_q <= DECEL_RESET;
			scale_q <= SCALE_RESET;
		end else if (wr_en) begin
			case (wr_index)
				REG_ACCEL: accel_q <= wr_data[STEP_W-1:0];
				REG_DECEL: decel_q <= wr_data[STEP_W-1:0];
				REG_SCALE: scale_q <= wr_data[SCALE_W-1:0];
				default: begin
					// unmapped index: drop the write
				end
			endcase
		end
	end

	assign steps.accel = accel_q;
	assign steps.decel = decel_q;

	assign adv_out  = valid_s2 && (!out_valid_q || out_ready);
	assign adv_s1   = valid_s1 && (!valid_s2 || adv_out);
	assign in_ready = !valid_s1 || adv_s1;
	assign in_acc   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				valid_s2 <= 1'b1;
			end else if (adv_out) begin
				valid_s2 <= 1'b0;
			end
			if (adv_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			left_s1  <= prep_cmd(left_command, scale_q);
			right_s1 <= prep_cmd(right_command, scale_q);
		end
		if (adv_s1) begin
			left_s2  <= left_tgt;
			right_s2 <= right_tgt;
		end
	end

	dmsr_shape u_left_shape (
		.cmd    (left_s1),
		.target (left_tgt)
	);

	dmsr_shape u_right_shape (
		.cmd    (right_s1),
		.target (right_tgt)
	);

	dmsr_ramp u_left_ramp (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv_out),
		.target  (left_s2),
		.steps   (steps),
		.reverse (left_reverse),
		.duty    (left_duty)
	);

	dmsr_ramp u_right_ramp (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv_out),
		.target  (right_s2),
		.steps   (steps),
		.reverse (right_reverse),
		.duty    (right_duty)
	);

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

@@ design/dmsr_checker.sv @@
// ----------------------------------------------------------------------------
// dmsr_checker
// Port-level checks of the dual motor speed ramp, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "dual_motor_speed_ramp_defines.svh"

module dmsr_checker
	import dmsr_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [DUTY_W-1:0] left_duty,
	input logic [DUTY_W-1:0] right_duty,
	input logic              left_reverse,
	input logic              right_reverse
);

	logic [2*DUTY_W+1:0] out_word;

	assign out_word = {left_reverse, left_duty, right_reverse, right_duty};

	// a stalled result word stays up
	`DMSR_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	// and keeps its payload
	`DMSR_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable(out_word))
	// duty never leaves its range
	`DMSR_ASSERT_NOW(a_duty_range, clk, arst_n, 1'b1, left_duty <= DUTY_MAX && right_duty <= DUTY_MAX)
	// an empty output means nothing can back up to the input
	`DMSR_ASSERT_NOW(a_ready_free, clk, arst_n, !out_valid, in_ready)

endmodule

bind dual_motor_speed_ramp dmsr_checker u_dmsr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.left_duty     (left_duty),
	.right_duty    (right_duty),
	.left_reverse  (left_reverse),
	.right_reverse (right_reverse)
);

`default_nettype wire
